@@ hdl/owm_pkg.sv @@
package owm_pkg;

   // Bus sequence constants
   localparam int ROM_BYTES   = 8;
   localparam int BYTE_GAP_US = 100;

   // Timing register file
   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int US_W      = 10;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = REG_IDX_W + 2;

   localparam logic [US_W-1:0] US_MAX = {US_W{1'b1}};

   localparam logic [REG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PRESENCE_SAMPLE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_WRITE_LOW      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_WRITE_SLOT     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_READ_LOW       = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_READ_RECOVERY  = 3'd7;

   localparam logic [US_W-1:0] REG_RESET_VALUE [NUM_REGS] = '{
      10'd500, 10'd30, 10'd470, 10'd5, 10'd80, 10'd2, 10'd15, 10'd15
   };

   // Command codes
   localparam logic [2:0] CMD_RESET    = 3'd0;
   localparam logic [2:0] CMD_WR_BIT   = 3'd1;
   localparam logic [2:0] CMD_RD_BIT   = 3'd2;
   localparam logic [2:0] CMD_WR_BYTE  = 3'd3;
   localparam logic [2:0] CMD_RD_BYTE  = 3'd4;
   localparam logic [2:0] CMD_READ_ROM = 3'd5;
   localparam logic [2:0] CMD_MATCH_ROM = 3'd6;
   localparam logic [2:0] CMD_SKIP_ROM = 3'd7;

   // ROM function opcodes sent on the bus
   localparam logic [7:0] OP_READ_ROM  = 8'h33;
   localparam logic [7:0] OP_MATCH_ROM = 8'h55;
   localparam logic [7:0] OP_SKIP_ROM  = 8'hCC;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int BYTE_POS_W = $clog2(ROM_BYTES + 1);
   localparam int ROM_IDX_W  = 3;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_WAIT,
      PH_RST_TAIL,
      PH_WR_LOW,
      PH_WR_HOLD,
      PH_RD_LOW,
      PH_RD_WAIT,
      PH_RD_REC,
      PH_GAP
   } phase_type;

   // One classified item: raw fields plus the decoded start of a command
   typedef struct packed {
      logic           us_tick;
      logic           line_level;
      logic           cmd_valid;
      logic [2:0]     cmd;
      logic           load_valid;
      logic [7:0]     data_byte;
      logic [2:0]     buffer_index;
      phase_type      start_phase;
      logic [7:0]     start_shift;
   } req_item_type;

   typedef struct packed {
      logic [US_W-1:0] reset_low_us;
      logic [US_W-1:0] presence_sample_us;
      logic [US_W-1:0] reset_tail_us;
      logic [US_W-1:0] write_low_us;
      logic [US_W-1:0] write_slot_us;
      logic [US_W-1:0] read_low_us;
      logic [US_W-1:0] read_sample_us;
      logic [US_W-1:0] read_recovery_us;
   } cfg_type;

endpackage

@@ hdl/owm_front.sv @@
module owm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_us_tick,
   input  logic                  req_line_level,
   input  logic                  req_cmd_valid,
   input  logic [2:0]            req_cmd,
   input  logic                  req_load_valid,
   input  logic [7:0]            req_data_byte,
   input  logic [2:0]            req_buffer_index,
   output logic                  head_valid,
   output owm_pkg::req_item_type head_item,
   input  logic                  head_pop
);

   owm_pkg::req_item_type                 item_in;
   owm_pkg::req_item_type                 q_mem_ff [owm_pkg::QUEUE_DEPTH];
   logic [owm_pkg::QPTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [owm_pkg::QPTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [owm_pkg::QCNT_W-1:0]            count_ff, count_in;
   logic                                  push;

   // Classify the command: first phase and first byte on the shifter
   always_comb begin
      item_in.us_tick      = req_us_tick;
      item_in.line_level   = req_line_level;
      item_in.cmd_valid    = req_cmd_valid;
      item_in.cmd          = req_cmd;
      item_in.load_valid   = req_load_valid;
      item_in.data_byte    = req_data_byte;
      item_in.buffer_index = req_buffer_index;
      item_in.start_phase  = owm_pkg::PH_WR_LOW;
      item_in.start_shift  = 8'h00;
      unique case (req_cmd)
         owm_pkg::CMD_RESET: begin
            item_in.start_phase = owm_pkg::PH_RST_LOW;
         end
         owm_pkg::CMD_WR_BIT: begin
            item_in.start_shift = {7'b0, req_data_byte[0]};
         end
         owm_pkg::CMD_RD_BIT, owm_pkg::CMD_RD_BYTE: begin
            item_in.start_phase = owm_pkg::PH_RD_LOW;
         end
         owm_pkg::CMD_WR_BYTE: begin
            item_in.start_shift = req_data_byte;
         end
         owm_pkg::CMD_READ_ROM: begin
            item_in.start_shift = owm_pkg::OP_READ_ROM;
         end
         owm_pkg::CMD_MATCH_ROM: begin
            item_in.start_shift = owm_pkg::OP_MATCH_ROM;
         end
         owm_pkg::CMD_SKIP_ROM: begin
            item_in.start_shift = owm_pkg::OP_SKIP_ROM;
         end
      endcase
   end

   assign req_ready  = (count_ff != owm_pkg::QCNT_W'(owm_pkg::QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign head_item  = q_mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == owm_pkg::QPTR_W'(owm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == owm_pkg::QPTR_W'(owm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

@@ hdl/owm_seq.sv @@
module owm_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  owm_pkg::cfg_type      cfg,
   input  logic                  head_valid,
   input  owm_pkg::req_item_type head_item,
   output logic                  head_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_line_pull_low,
   output logic                  rsp_busy_res,
   output logic                  rsp_result_valid,
   output logic [7:0]            rsp_result_data,
   output logic [2:0]            rsp_result_index,
   output logic                  rsp_result_last,
   output logic                  rsp_presence
);

   owm_pkg::phase_type                 phase_ff, phase_in;
   logic [owm_pkg::US_W-1:0]           us_count_ff, us_count_in;
   logic [2:0]                         bit_pos_ff, bit_pos_in;
   logic [owm_pkg::BYTE_POS_W-1:0]     byte_pos_ff, byte_pos_in;
   logic [7:0]                         shift_ff, shift_in;
   logic [2:0]                         active_ff, active_in;
   logic                               first_ff, first_in;
   logic                               presence_ff, presence_in;
   logic [7:0]                         rom_ff [owm_pkg::ROM_BYTES];

   logic                               rom_we;
   logic [owm_pkg::ROM_IDX_W-1:0]      rom_wa;
   logic [7:0]                         rom_wd;
   logic [owm_pkg::US_W-1:0]           lim;
   logic [owm_pkg::US_W-1:0]           cnt_inc;
   logic [owm_pkg::US_W-1:0]           tmr_next;
   logic                               done;
   logic                               fin;
   logic                               step;
   logic                               out_space;
   logic                               pull;
   logic                               res_valid;
   logic [7:0]                         res_data;
   logic [2:0]                         res_index;
   logic                               res_last;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               pull_ff, busy_ff, rvalid_ff, rlast_ff, pres_ff;
   logic [7:0]                         rdata_ff;
   logic [2:0]                         rindex_ff;

   assign out_space = !rsp_valid_ff || rsp_ready;
   assign step      = head_valid && out_space;
   assign head_pop  = step;

   // Pick the length of the current timed phase
   always_comb begin
      unique case (phase_ff)
         owm_pkg::PH_RST_LOW:  lim = cfg.reset_low_us;
         owm_pkg::PH_RST_WAIT: lim = cfg.presence_sample_us;
         owm_pkg::PH_RST_TAIL: lim = cfg.reset_tail_us;
         owm_pkg::PH_WR_LOW:   lim = cfg.write_low_us;
         owm_pkg::PH_WR_HOLD:  lim = cfg.write_slot_us;
         owm_pkg::PH_RD_LOW:   lim = cfg.read_low_us;
         owm_pkg::PH_RD_WAIT:  lim = cfg.read_sample_us;
         owm_pkg::PH_RD_REC:   lim = cfg.read_recovery_us;
         owm_pkg::PH_GAP:      lim = owm_pkg::US_W'(owm_pkg::BYTE_GAP_US);
         default:              lim = '0;
      endcase
   end

   // Count strobes with saturation, end the phase when the length is reached
   assign cnt_inc  = (head_item.us_tick && us_count_ff != owm_pkg::US_MAX) ?
                     us_count_ff + 1'b1 : us_count_ff;
   assign done     = (cnt_inc >= lim);
   assign tmr_next = done ? '0 : cnt_inc;

   // Next state and result of one step
   always_comb begin
      phase_in    = phase_ff;
      us_count_in = us_count_ff;
      bit_pos_in  = bit_pos_ff;
      byte_pos_in = byte_pos_ff;
      shift_in    = shift_ff;
      active_in   = active_ff;
      first_in    = first_ff;
      presence_in = presence_ff;
      rom_we      = 1'b0;
      rom_wa      = head_item.buffer_index;
      rom_wd      = head_item.data_byte;
      res_valid   = 1'b0;
      res_data    = 8'h00;
      res_index   = 3'd0;
      res_last    = 1'b0;
      fin         = 1'b0;

      unique case (phase_ff)
         owm_pkg::PH_IDLE: begin
            rom_we = head_item.load_valid;
            if (head_item.cmd_valid) begin
               active_in   = head_item.cmd;
               bit_pos_in  = '0;
               byte_pos_in = '0;
               us_count_in = '0;
               shift_in    = head_item.start_shift;
               phase_in    = head_item.start_phase;
            end
         end
         owm_pkg::PH_RST_LOW: begin
            us_count_in = tmr_next;
            if (done) begin
               phase_in = owm_pkg::PH_RST_WAIT;
            end
         end
         owm_pkg::PH_RST_WAIT: begin
            us_count_in = tmr_next;
            if (done) begin
               first_in = ~head_item.line_level;
               phase_in = owm_pkg::PH_RST_TAIL;
            end
         end
         owm_pkg::PH_RST_TAIL: begin
            us_count_in = tmr_next;
            if (done) begin
               presence_in = first_ff && head_item.line_level;
               res_data    = {7'b0, first_ff && head_item.line_level};
               fin         = 1'b1;
            end
         end
         owm_pkg::PH_WR_LOW: begin
            us_count_in = tmr_next;
            if (done) begin
               phase_in = owm_pkg::PH_WR_HOLD;
            end
         end
         owm_pkg::PH_WR_HOLD: begin
            us_count_in = tmr_next;
            if (done) begin
               if (active_ff == owm_pkg::CMD_WR_BIT) begin
                  fin = 1'b1;
               end else begin
                  shift_in = {1'b0, shift_ff[7:1]};
                  if (bit_pos_ff == 3'd7) begin
                     bit_pos_in = '0;
                     phase_in   = owm_pkg::PH_GAP;
                  end else begin
                     bit_pos_in = bit_pos_ff + 1'b1;
                     phase_in   = owm_pkg::PH_WR_LOW;
                  end
               end
            end
         end
         owm_pkg::PH_GAP: begin
            us_count_in = tmr_next;
            if (done) begin
               if (active_ff == owm_pkg::CMD_READ_ROM) begin
                  byte_pos_in = '0;
                  shift_in    = 8'h00;
                  phase_in    = owm_pkg::PH_RD_LOW;
               end else if (active_ff == owm_pkg::CMD_MATCH_ROM &&
                            byte_pos_ff < owm_pkg::BYTE_POS_W'(owm_pkg::ROM_BYTES)) begin
                  shift_in    = rom_ff[byte_pos_ff[owm_pkg::ROM_IDX_W-1:0]];
                  byte_pos_in = byte_pos_ff + 1'b1;
                  phase_in    = owm_pkg::PH_WR_LOW;
               end else begin
                  fin = 1'b1;
               end
            end
         end
         owm_pkg::PH_RD_LOW: begin
            us_count_in = tmr_next;
            if (done) begin
               phase_in = owm_pkg::PH_RD_WAIT;
            end
         end
         owm_pkg::PH_RD_WAIT: begin
            us_count_in = tmr_next;
            if (done) begin
               if (active_ff == owm_pkg::CMD_RD_BIT) begin
                  res_data = {7'b0, head_item.line_level};
                  fin      = 1'b1;
               end else begin
                  shift_in = {head_item.line_level, shift_ff[7:1]};
                  phase_in = owm_pkg::PH_RD_REC;
               end
            end
         end
         owm_pkg::PH_RD_REC: begin
            us_count_in = tmr_next;
            if (done) begin
               if (bit_pos_ff != 3'd7) begin
                  bit_pos_in = bit_pos_ff + 1'b1;
                  phase_in   = owm_pkg::PH_RD_LOW;
               end else if (active_ff == owm_pkg::CMD_READ_ROM) begin
                  // Store and report each ROM byte
                  rom_we    = 1'b1;
                  rom_wa    = byte_pos_ff[owm_pkg::ROM_IDX_W-1:0];
                  rom_wd    = shift_ff;
                  res_valid = 1'b1;
                  res_data  = shift_ff;
                  res_index = byte_pos_ff[owm_pkg::ROM_IDX_W-1:0];
                  if (byte_pos_ff + 1'b1 >= owm_pkg::BYTE_POS_W'(owm_pkg::ROM_BYTES)) begin
                     res_last = 1'b1;
                     phase_in = owm_pkg::PH_IDLE;
                  end else begin
                     byte_pos_in = byte_pos_ff + 1'b1;
                     bit_pos_in  = '0;
                     shift_in    = 8'h00;
                     phase_in    = owm_pkg::PH_RD_LOW;
                  end
               end else begin
                  res_data = shift_ff;
                  fin      = 1'b1;
               end
            end
         end
         default: begin
            phase_in = owm_pkg::PH_IDLE;
         end
      endcase

      if (fin) begin
         res_valid = 1'b1;
         res_last  = 1'b1;
         phase_in  = owm_pkg::PH_IDLE;
      end
   end

   // Drive the bus low in low phases, and in a write hold for a zero bit
   always_comb begin
      pull = 1'b0;
      if (phase_in == owm_pkg::PH_RST_LOW || phase_in == owm_pkg::PH_WR_LOW ||
          phase_in == owm_pkg::PH_RD_LOW) begin
         pull = 1'b1;
      end else if (phase_in == owm_pkg::PH_WR_HOLD && !shift_in[0]) begin
         pull = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= owm_pkg::PH_IDLE;
         us_count_ff  <= '0;
         bit_pos_ff   <= '0;
         byte_pos_ff  <= '0;
         shift_ff     <= '0;
         active_ff    <= '0;
         first_ff     <= 1'b0;
         presence_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            phase_ff    <= phase_in;
            us_count_ff <= us_count_in;
            bit_pos_ff  <= bit_pos_in;
            byte_pos_ff <= byte_pos_in;
            shift_ff    <= shift_in;
            active_ff   <= active_in;
            first_ff    <= first_in;
            presence_ff <= presence_in;
         end
      end
   end

   // ROM buffer and result register
   always_ff @(posedge clock) begin
      if (step && rom_we) begin
         rom_ff[rom_wa] <= rom_wd;
      end
      if (step) begin
         pull_ff   <= pull;
         busy_ff   <= (phase_in != owm_pkg::PH_IDLE);
         rvalid_ff <= res_valid;
         rdata_ff  <= res_data;
         rindex_ff <= res_index;
         rlast_ff  <= res_last;
         pres_ff   <= presence_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_pull_low = pull_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_result_valid  = rvalid_ff;
   assign rsp_result_data   = rdata_ff;
   assign rsp_result_index  = rindex_ff;
   assign rsp_result_last   = rlast_ff;
   assign rsp_presence      = pres_ff;

endmodule

@@ hdl/one_wire_bus_master.sv @@
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | us_tick, line_level, cmd_valid, cmd, load_valid,
//         |           |                      | data_byte, buffer_index
// rsp     | out       | rsp_valid/rsp_ready  | line_pull_low, busy_res, result_valid, result_data,
//         |           |                      | result_index, result_last, presence
// csr     | in/out    | APB psel/penable     | eight 10-bit slot timings at byte address 4*i
//
// One item is taken per clock cycle sustained while rsp keeps up; its result reaches rsp
// through the two-entry command queue, which the transfer fills, and then the result
// register, which a sequencer step fills.
// The sequencer steps once per item and needs rsp space to do so; a stalled rsp fills the
// queue, after which req_ready drops until a result transfers.
// Synchronous active-high reset idles the sequencer, empties the queue and loads the default
// timings; the ROM buffer holds whatever was last written.
module one_wire_bus_master (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_us_tick,
   input  logic                              req_line_level,
   input  logic                              req_cmd_valid,
   input  logic [2:0]                        req_cmd,
   input  logic                              req_load_valid,
   input  logic [7:0]                        req_data_byte,
   input  logic [2:0]                        req_buffer_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_line_pull_low,
   output logic                              rsp_busy_res,
   output logic                              rsp_result_valid,
   output logic [7:0]                        rsp_result_data,
   output logic [2:0]                        rsp_result_index,
   output logic                              rsp_result_last,
   output logic                              rsp_presence,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [owm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [owm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [owm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic [owm_pkg::US_W-1:0]       csr_reg_ff [owm_pkg::NUM_REGS];
   logic [owm_pkg::REG_IDX_W-1:0]  csr_idx;
   logic                           csr_wr;
   owm_pkg::cfg_type               cfg;
   owm_pkg::req_item_type          head_item;
   logic                           head_valid;
   logic                           head_pop;

   // Register file write and read
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[owm_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = {{(owm_pkg::CSR_DATA_W - owm_pkg::US_W){1'b0}}, csr_reg_ff[csr_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_reg_ff <= owm_pkg::REG_RESET_VALUE;
      end else if (csr_wr) begin
         csr_reg_ff[csr_idx] <= csr_pwdata[owm_pkg::US_W-1:0];
      end
   end

   assign cfg.reset_low_us       = csr_reg_ff[owm_pkg::REG_RESET_LOW];
   assign cfg.presence_sample_us = csr_reg_ff[owm_pkg::REG_PRESENCE_SAMPLE];
   assign cfg.reset_tail_us      = csr_reg_ff[owm_pkg::REG_RESET_TAIL];
   assign cfg.write_low_us       = csr_reg_ff[owm_pkg::REG_WRITE_LOW];
   assign cfg.write_slot_us      = csr_reg_ff[owm_pkg::REG_WRITE_SLOT];
   assign cfg.read_low_us        = csr_reg_ff[owm_pkg::REG_READ_LOW];
   assign cfg.read_sample_us     = csr_reg_ff[owm_pkg::REG_READ_SAMPLE];
   assign cfg.read_recovery_us   = csr_reg_ff[owm_pkg::REG_READ_RECOVERY];

   owm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_us_tick      (req_us_tick),
      .req_line_level   (req_line_level),
      .req_cmd_valid    (req_cmd_valid),
      .req_cmd          (req_cmd),
      .req_load_valid   (req_load_valid),
      .req_data_byte    (req_data_byte),
      .req_buffer_index (req_buffer_index),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .head_pop         (head_pop)
   );

   owm_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .head_valid        (head_valid),
      .head_item         (head_item),
      .head_pop          (head_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_pull_low (rsp_line_pull_low),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_result_valid  (rsp_result_valid),
      .rsp_result_data   (rsp_result_data),
      .rsp_result_index  (rsp_result_index),
      .rsp_result_last   (rsp_result_last),
      .rsp_presence      (rsp_presence)
   );

   // A full queue only comes from a stalled result
   a_full_needs_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("command queue full without a pending result");

   // The last flag only marks a valid result
   a_last_is_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_last) |-> rsp_result_valid)
      else $error("result_last without result_valid");

   // An idle master releases the bus
   a_idle_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_busy_res) |-> !rsp_line_pull_low)
      else $error("bus pulled low while idle");

   // A byte position is reported only with a result
   a_index_with_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_index != 3'd0) |-> rsp_result_valid)
      else $error("result_index set without a result");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

   // One bus step as offered on req
   typedef struct packed {
      logic       tick;
      logic       line;
      logic       cmd_valid;
      logic [2:0] cmd;
      logic       load_valid;
      logic [7:0] data;
      logic [2:0] bidx;
   } bus_step_type;

   // Outputs produced for one bus step
   typedef struct packed {
      logic       pull;
      logic       busy;
      logic       rvalid;
      logic [7:0] rdata;
      logic [2:0] rindex;
      logic       rlast;
      logic       pres;
   } bus_result_type;

   logic                           clock;
   logic                           reset            = 1'b1;
   logic                           req_valid        = 1'b0;
   logic                           req_ready;
   logic                           req_us_tick      = 1'b0;
   logic                           req_line_level   = 1'b0;
   logic                           req_cmd_valid    = 1'b0;
   logic [2:0]                     req_cmd          = owm_pkg::CMD_RESET;
   logic                           req_load_valid   = 1'b0;
   logic [7:0]                     req_data_byte    = '0;
   logic [2:0]                     req_buffer_index = '0;
   logic                           rsp_valid;
   logic                           rsp_ready        = 1'b0;
   logic                           rsp_line_pull_low;
   logic                           rsp_busy_res;
   logic                           rsp_result_valid;
   logic [7:0]                     rsp_result_data;
   logic [2:0]                     rsp_result_index;
   logic                           rsp_result_last;
   logic                           rsp_presence;
   logic                           csr_psel         = 1'b0;
   logic                           csr_penable      = 1'b0;
   logic                           csr_pwrite       = 1'b0;
   logic [owm_pkg::CSR_ADDR_W-1:0] csr_paddr        = '0;
   logic [owm_pkg::CSR_DATA_W-1:0] csr_pwdata       = '0;
   logic [owm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Sequencer mirror
   owm_pkg::phase_type             seq_ph;
   logic [owm_pkg::US_W-1:0]       us_cnt;
   logic [2:0]                     bit_idx;
   logic [3:0]                     byte_idx;
   logic [7:0]                     shreg;
   logic [2:0]                     act_cmd;
   logic                           first_low;
   logic                           present;
   logic [7:0]                     rom_img [owm_pkg::ROM_BYTES];
   owm_pkg::cfg_type               timing;

   // Emulated slave on the bus
   logic                           dev_first;
   logic                           dev_second;
   logic [7:0]                     dev_image [owm_pkg::ROM_BYTES];

   bus_result_type                 pending_results [$];
   int                             mismatches    = 0;
   int                             send_idle_pct = 0;
   int                             rsp_stall_pct = 0;
   int                             quiet_sends   = 0;
   int                             quiet_rsps    = 0;

   one_wire_bus_master u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_us_tick      (req_us_tick),
      .req_line_level   (req_line_level),
      .req_cmd_valid    (req_cmd_valid),
      .req_cmd          (req_cmd),
      .req_load_valid   (req_load_valid),
      .req_data_byte    (req_data_byte),
      .req_buffer_index (req_buffer_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_pull_low(rsp_line_pull_low),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_result_valid (rsp_result_valid),
      .rsp_result_data  (rsp_result_data),
      .rsp_result_index (rsp_result_index),
      .rsp_result_last  (rsp_result_last),
      .rsp_presence     (rsp_presence),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < 100)
         $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   // Count strobes toward a slot length; a zero length ends at once
   function automatic logic slot_done(input logic [owm_pkg::US_W-1:0] lim, input logic tick);
      if (tick && us_cnt != owm_pkg::US_MAX)
         us_cnt = us_cnt + 1'b1;
      if (us_cnt >= lim) begin
         us_cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advance the sequencer mirror by one bus step and return its outputs
   function automatic bus_result_type step_sequencer(input bus_step_type s);
      bus_result_type r;
      logic           fin;
      r = '0;
      fin = 1'b0;
      case (seq_ph)
         owm_pkg::PH_IDLE: begin
            // Load lands before a command taken in the same step
            if (s.load_valid)
               rom_img[s.bidx] = s.data;
            if (s.cmd_valid) begin
               act_cmd = s.cmd;
               bit_idx = '0;
               byte_idx = '0;
               us_cnt = '0;
               shreg = '0;
               case (s.cmd)
                  owm_pkg::CMD_RESET: seq_ph = owm_pkg::PH_RST_LOW;
                  owm_pkg::CMD_WR_BIT: begin
                     shreg = {7'd0, s.data[0]};
                     seq_ph = owm_pkg::PH_WR_LOW;
                  end
                  owm_pkg::CMD_RD_BIT, owm_pkg::CMD_RD_BYTE: seq_ph = owm_pkg::PH_RD_LOW;
                  owm_pkg::CMD_WR_BYTE: begin
                     shreg = s.data;
                     seq_ph = owm_pkg::PH_WR_LOW;
                  end
                  owm_pkg::CMD_READ_ROM: begin
                     shreg = owm_pkg::OP_READ_ROM;
                     seq_ph = owm_pkg::PH_WR_LOW;
                  end
                  owm_pkg::CMD_MATCH_ROM: begin
                     shreg = owm_pkg::OP_MATCH_ROM;
                     seq_ph = owm_pkg::PH_WR_LOW;
                  end
                  default: begin
                     shreg = owm_pkg::OP_SKIP_ROM;
                     seq_ph = owm_pkg::PH_WR_LOW;
                  end
               endcase
            end
         end
         owm_pkg::PH_RST_LOW: begin
            if (slot_done(timing.reset_low_us, s.tick))
               seq_ph = owm_pkg::PH_RST_WAIT;
         end
         owm_pkg::PH_RST_WAIT: begin
            if (slot_done(timing.presence_sample_us, s.tick)) begin
               first_low = !s.line;
               seq_ph = owm_pkg::PH_RST_TAIL;
            end
         end
         owm_pkg::PH_RST_TAIL: begin
            // Present only if pulled low first and released by the end
            if (slot_done(timing.reset_tail_us, s.tick)) begin
               present = first_low && s.line;
               r.rdata = {7'd0, present};
               fin = 1'b1;
            end
         end
         owm_pkg::PH_WR_LOW: begin
            if (slot_done(timing.write_low_us, s.tick))
               seq_ph = owm_pkg::PH_WR_HOLD;
         end
         owm_pkg::PH_WR_HOLD: begin
            if (slot_done(timing.write_slot_us, s.tick)) begin
               if (act_cmd == owm_pkg::CMD_WR_BIT) begin
                  fin = 1'b1;
               end else begin
                  shreg = shreg >> 1;
                  if (bit_idx == 3'd7) begin
                     bit_idx = '0;
                     seq_ph = owm_pkg::PH_GAP;
                  end else begin
                     bit_idx = bit_idx + 1'b1;
                     seq_ph = owm_pkg::PH_WR_LOW;
                  end
               end
            end
         end
         owm_pkg::PH_GAP: begin
            // After a byte: start the ROM read, send the next buffered byte, or finish
            if (slot_done(owm_pkg::US_W'(owm_pkg::BYTE_GAP_US), s.tick)) begin
               if (act_cmd == owm_pkg::CMD_READ_ROM) begin
                  byte_idx = '0;
                  shreg = '0;
                  seq_ph = owm_pkg::PH_RD_LOW;
               end else if (act_cmd == owm_pkg::CMD_MATCH_ROM &&
                            byte_idx < owm_pkg::ROM_BYTES) begin
                  shreg = rom_img[byte_idx[2:0]];
                  byte_idx = byte_idx + 1'b1;
                  seq_ph = owm_pkg::PH_WR_LOW;
               end else begin
                  fin = 1'b1;
               end
            end
         end
         owm_pkg::PH_RD_LOW: begin
            if (slot_done(timing.read_low_us, s.tick))
               seq_ph = owm_pkg::PH_RD_WAIT;
         end
         owm_pkg::PH_RD_WAIT: begin
            if (slot_done(timing.read_sample_us, s.tick)) begin
               if (act_cmd == owm_pkg::CMD_RD_BIT) begin
                  r.rdata = {7'd0, s.line};
                  fin = 1'b1;
               end else begin
                  shreg = {s.line, shreg[7:1]};
                  seq_ph = owm_pkg::PH_RD_REC;
               end
            end
         end
         owm_pkg::PH_RD_REC: begin
            if (slot_done(timing.read_recovery_us, s.tick)) begin
               if (bit_idx < 3'd7) begin
                  bit_idx = bit_idx + 1'b1;
                  seq_ph = owm_pkg::PH_RD_LOW;
               end else if (act_cmd == owm_pkg::CMD_READ_ROM) begin
                  // Store and report each ROM byte as it completes
                  rom_img[byte_idx[2:0]] = shreg;
                  r.rvalid = 1'b1;
                  r.rdata = shreg;
                  r.rindex = byte_idx[2:0];
                  if (int'(byte_idx) + 1 >= owm_pkg::ROM_BYTES) begin
                     r.rlast = 1'b1;
                     seq_ph = owm_pkg::PH_IDLE;
                  end else begin
                     byte_idx = byte_idx + 1'b1;
                     bit_idx = '0;
                     shreg = '0;
                     seq_ph = owm_pkg::PH_RD_LOW;
                  end
               end else begin
                  r.rdata = shreg;
                  fin = 1'b1;
               end
            end
         end
         default: seq_ph = owm_pkg::PH_IDLE;
      endcase
      if (fin) begin
         r.rvalid = 1'b1;
         r.rlast = 1'b1;
         seq_ph = owm_pkg::PH_IDLE;
      end
      r.pull = (seq_ph == owm_pkg::PH_RST_LOW) || (seq_ph == owm_pkg::PH_WR_LOW) ||
               (seq_ph == owm_pkg::PH_RD_LOW) ||
               (seq_ph == owm_pkg::PH_WR_HOLD && !shreg[0]);
      r.busy = (seq_ph != owm_pkg::PH_IDLE);
      r.pres = present;
      return r;
   endfunction

   // Line level the emulated slave shows in the coming step
   function automatic logic device_line();
      case (seq_ph)
         owm_pkg::PH_RST_WAIT: return dev_first;
         owm_pkg::PH_RST_TAIL: return dev_second;
         owm_pkg::PH_RD_WAIT:  return dev_image[byte_idx[2:0]][bit_idx];
         default:              return 1'($urandom_range(1));
      endcase
   endfunction

   // Step during a command: commands and loads here are ignored by the block
   function automatic bus_step_type busy_step(input logic exact);
      bus_step_type s;
      s.tick = ($urandom_range(7) != 0);
      s.line = (exact || $urandom_range(7) != 0) ? device_line() : 1'($urandom_range(1));
      s.cmd_valid = ($urandom_range(3) == 0);
      s.cmd = 3'($urandom_range(7));
      s.load_valid = ($urandom_range(3) == 0);
      s.data = 8'($urandom);
      s.bidx = 3'($urandom_range(7));
      return s;
   endfunction

   // Step while idle: start a command one time in three, mostly a short one, rarely a skip
   function automatic bus_step_type idle_step();
      bus_step_type s;
      int           pick;
      s = busy_step(1'b0);
      s.cmd_valid = ($urandom_range(2) == 0);
      pick = $urandom_range(31);
      if (pick < 7)
         s.cmd = owm_pkg::CMD_RESET;
      else if (pick < 13)
         s.cmd = owm_pkg::CMD_WR_BIT;
      else if (pick < 19)
         s.cmd = owm_pkg::CMD_RD_BIT;
      else if (pick < 23)
         s.cmd = owm_pkg::CMD_WR_BYTE;
      else if (pick < 29)
         s.cmd = owm_pkg::CMD_RD_BYTE;
      else
         s.cmd = owm_pkg::CMD_SKIP_ROM;
      if (s.cmd_valid) begin
         dev_first = ($urandom_range(3) != 0) ? 1'b0 : 1'($urandom_range(1));
         dev_second = ($urandom_range(3) != 0) ? 1'b1 : 1'($urandom_range(1));
         for (int i = 0; i < owm_pkg::ROM_BYTES; i++)
            dev_image[i] = 8'($urandom);
      end
      return s;
   endfunction

   // Offer one step on req, hold it until the transfer, then predict its result
   task automatic drive_step(input bus_step_type s);
      if (quiet_sends != 0)
         quiet_sends--;
      else if ($urandom_range(99) == 0)
         quiet_sends = 25;
      if (quiet_sends == 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_us_tick <= s.tick;
      req_line_level <= s.line;
      req_cmd_valid <= s.cmd_valid;
      req_cmd <= s.cmd;
      req_load_valid <= s.load_valid;
      req_data_byte <= s.data;
      req_buffer_index <= s.bidx;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(step_sequencer(s));
   endtask

   // Drop valid and hold off until every result has transferred
   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [owm_pkg::REG_IDX_W-1:0] idx,
                            input logic [owm_pkg::US_W-1:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {22'($urandom), v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      timing[(owm_pkg::NUM_REGS - 1 - int'(idx)) * owm_pkg::US_W +: owm_pkg::US_W] = v;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [owm_pkg::REG_IDX_W-1:0] idx);
      logic [owm_pkg::US_W-1:0] want;
      want = timing[(owm_pkg::NUM_REGS - 1 - int'(idx)) * owm_pkg::US_W +: owm_pkg::US_W];
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== owm_pkg::CSR_DATA_W'(want))
         report_mismatch($sformatf("prdata reg %0d", idx), csr_prdata,
                         owm_pkg::CSR_DATA_W'(want));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write all slot timings once the block has gone quiet
   task automatic program_timings(input owm_pkg::cfg_type c);
      wait_all_results();
      for (int i = 0; i < owm_pkg::NUM_REGS; i++)
         csr_write(owm_pkg::REG_IDX_W'(i),
                   c[(owm_pkg::NUM_REGS - 1 - i) * owm_pkg::US_W +: owm_pkg::US_W]);
   endtask

   function automatic owm_pkg::cfg_type default_timing();
      owm_pkg::cfg_type c;
      for (int i = 0; i < owm_pkg::NUM_REGS; i++)
         c[(owm_pkg::NUM_REGS - 1 - i) * owm_pkg::US_W +: owm_pkg::US_W] =
            owm_pkg::REG_RESET_VALUE[i];
      return c;
   endfunction

   function automatic owm_pkg::cfg_type random_timing(input int top);
      owm_pkg::cfg_type c;
      for (int i = 0; i < owm_pkg::NUM_REGS; i++)
         c[i * owm_pkg::US_W +: owm_pkg::US_W] = owm_pkg::US_W'($urandom_range(top));
      return c;
   endfunction

   // Start a command (with an optional load in the same step) and run it to the end
   task automatic run_command(input logic [2:0] c, input logic [7:0] d,
                              input logic ld, input logic [2:0] ld_idx);
      bus_step_type s;
      s = busy_step(1'b1);
      s.cmd_valid = 1'b1;
      s.cmd = c;
      s.data = d;
      s.load_valid = ld;
      s.bidx = ld_idx;
      drive_step(s);
      while (seq_ph != owm_pkg::PH_IDLE)
         drive_step(busy_step(1'b1));
   endtask

   task automatic load_entry(input logic [2:0] idx, input logic [7:0] v);
      bus_step_type s;
      s = busy_step(1'b1);
      s.cmd_valid = 1'b0;
      s.load_valid = 1'b1;
      s.bidx = idx;
      s.data = v;
      drive_step(s);
   endtask

   task automatic test_csr_access();
      for (int i = 0; i < owm_pkg::NUM_REGS; i++)
         csr_check(owm_pkg::REG_IDX_W'(i));
      program_timings(random_timing(1023));
      for (int i = 0; i < owm_pkg::NUM_REGS; i++)
         csr_check(owm_pkg::REG_IDX_W'(i));
      program_timings(owm_pkg::cfg_type'({owm_pkg::NUM_REGS{owm_pkg::US_MAX}}));
      for (int i = 0; i < owm_pkg::NUM_REGS; i++)
         csr_check(owm_pkg::REG_IDX_W'(i));
      program_timings(default_timing());
   endtask

   task automatic test_buffer_load();
      load_entry(3'd0, 8'h00);
      load_entry(3'd1, 8'hFF);
      load_entry(3'd2, 8'h5A);
      load_entry(3'd3, 8'hA5);
      load_entry(3'd4, 8'h01);
      load_entry(3'd5, 8'h80);
      load_entry(3'd6, 8'h3C);
      load_entry(3'd7, 8'hC3);
   endtask

   task automatic test_reset_presence();
      program_timings(owm_pkg::cfg_type'({owm_pkg::NUM_REGS{10'd3}}));
      // A device answering
      dev_first = 1'b0;
      dev_second = 1'b1;
      run_command(owm_pkg::CMD_RESET, 8'h00, 1'b0, 3'd0);
      // Every combination of the two presence samples
      for (int k = 0; k < 4; k++) begin
         dev_first = k[0];
         dev_second = k[1];
         run_command(owm_pkg::CMD_RESET, 8'h00, 1'b0, 3'd0);
      end
   endtask

   task automatic test_bit_slots();
      run_command(owm_pkg::CMD_WR_BIT, 8'hFE, 1'b0, 3'd0);
      run_command(owm_pkg::CMD_WR_BIT, 8'h01, 1'b0, 3'd0);
      dev_image[0] = 8'h00;
      run_command(owm_pkg::CMD_RD_BIT, 8'h00, 1'b0, 3'd0);
      dev_image[0] = 8'hFF;
      run_command(owm_pkg::CMD_RD_BIT, 8'h00, 1'b0, 3'd0);
   endtask

   task automatic test_byte_slots();
      program_timings(owm_pkg::cfg_type'('0));
      // Load and write in one step use the same data byte
      run_command(owm_pkg::CMD_WR_BYTE, 8'hA5, 1'b1, 3'd2);
      dev_image[0] = 8'h00;
      run_command(owm_pkg::CMD_RD_BYTE, 8'h00, 1'b0, 3'd0);
      dev_image[0] = 8'hFF;
      run_command(owm_pkg::CMD_RD_BYTE, 8'h00, 1'b0, 3'd0);
      dev_image[0] = 8'h96;
      run_command(owm_pkg::CMD_RD_BYTE, 8'h00, 1'b0, 3'd0);
   endtask

   task automatic test_rom_functions();
      program_timings(owm_pkg::cfg_type'('0));
      for (int i = 0; i < owm_pkg::ROM_BYTES; i++)
         dev_image[i] = 8'($urandom);
      run_command(owm_pkg::CMD_READ_ROM, 8'h00, 1'b0, 3'd0);
      // Last buffer entry is reloaded in the step that starts the match
      run_command(owm_pkg::CMD_MATCH_ROM, 8'h3C, 1'b1, 3'd7);
   endtask

   task automatic test_timing_extremes();
      program_timings(owm_pkg::cfg_type'('0));
      dev_first = 1'b0;
      dev_second = 1'b1;
      run_command(owm_pkg::CMD_RESET, 8'h00, 1'b0, 3'd0);
      run_command(owm_pkg::CMD_WR_BIT, 8'h00, 1'b0, 3'd0);
      dev_image[0] = 8'h01;
      run_command(owm_pkg::CMD_RD_BIT, 8'h00, 1'b0, 3'd0);
   endtask

   // Random command streams with random slave answers under one idling profile
   task automatic test_random_traffic(input int n_steps, input int send_pct,
                                      input int stall_pct, input logic zero_timing);
      program_timings(zero_timing ? owm_pkg::cfg_type'('0) : random_timing(6));
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (int k = 0; k < n_steps; k++)
         drive_step((seq_ph == owm_pkg::PH_IDLE) ? idle_step() : busy_step(1'b0));
      // Run the open command out so the next phase starts idle
      while (seq_ph != owm_pkg::PH_IDLE)
         drive_step(busy_step(1'b0));
   endtask

   // Check each result transfer against the oldest prediction; pace rsp_ready
   always @(posedge clock) begin : rsp_monitor
      bus_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", 0, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_line_pull_low !== want.pull)
               report_mismatch("line_pull_low", rsp_line_pull_low, want.pull);
            if (rsp_busy_res !== want.busy)
               report_mismatch("busy_res", rsp_busy_res, want.busy);
            if (rsp_result_valid !== want.rvalid)
               report_mismatch("result_valid", rsp_result_valid, want.rvalid);
            if (rsp_result_data !== want.rdata)
               report_mismatch("result_data", rsp_result_data, want.rdata);
            if (rsp_result_index !== want.rindex)
               report_mismatch("result_index", rsp_result_index, want.rindex);
            if (rsp_result_last !== want.rlast)
               report_mismatch("result_last", rsp_result_last, want.rlast);
            if (rsp_presence !== want.pres)
               report_mismatch("presence", rsp_presence, want.pres);
         end
      end
      if (quiet_rsps != 0)
         quiet_rsps--;
      else if ($urandom_range(99) == 0)
         quiet_rsps = 25;
      rsp_ready <= (quiet_rsps != 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      seq_ph = owm_pkg::PH_IDLE;
      us_cnt = '0;
      bit_idx = '0;
      byte_idx = '0;
      shreg = '0;
      act_cmd = owm_pkg::CMD_RESET;
      first_low = 1'b0;
      present = 1'b0;
      timing = default_timing();
      dev_first = 1'b0;
      dev_second = 1'b1;
      for (int i = 0; i < owm_pkg::ROM_BYTES; i++) begin
         rom_img[i] = '0;
         dev_image[i] = '0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_csr_access();
      test_buffer_load();
      test_reset_presence();
      test_bit_slots();
      test_byte_slots();
      test_rom_functions();
      test_timing_extremes();
      test_random_traffic(50, 0, 0, 1'b1);
      test_random_traffic(50, 78, 0, 1'b0);
      test_random_traffic(50, 0, 78, 1'b0);
      test_random_traffic(50, 38, 38, 1'b0);

      wait_all_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ one_wire_bus_master.f @@
hdl/owm_pkg.sv
hdl/owm_front.sv
hdl/owm_seq.sv
hdl/one_wire_bus_master.sv
bench/tb.sv
